// File: rtl/linear_blend_skinning_assert.svh
// Assertion macros for the skinning RTL, included by lbs_back
`ifndef LINEAR_BLEND_SKINNING_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LBS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbs assertion failed");

// Next-cycle implication, checked outside reset
`define LBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbs assertion failed");

`endif

// File: rtl/lbs_pkg.sv
// Shared types, constants and helpers for the skinning block
`default_nettype none

package lbs_pkg;

   localparam int WT_W   = 24;
   localparam int ACC_W  = 56;
   localparam int OPA_W  = 42;
   localparam int OPB_W  = 20;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int FRAC_Q = 14;

   // Request class decided at the front
   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_APPLY = 2'd1,
      KIND_SKIP  = 2'd2
   } kind_type;

   // One queued request
   typedef struct packed {
      kind_type           kind;
      logic               last;
      logic [7:0]         bone;
      logic [15:0]        weight;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } job_type;

   // Queue handshake between front and back
   typedef struct packed {
      logic    empty;
      job_type head;
   } queue_type;

   // Saturating signed 64-bit add
   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/linear_blend_skinning.sv
// Top level of the quaternion-bone linear blend skinning block
//
// Requests enter through req_push/req_full; a request is taken on a clock edge
// with req_push high and req_full low. func = 0 loads a bone entry (rotation
// quaternion and translation); func = 1 applies an influence to the current point.
// The influence marked last_influence produces one result on rsp_*: the result
// is valid while rsp_empty is low and is taken on an edge with rsp_pop high.
// csr_we/csr_wdata write bones_in_use; write it only while the block is idle.
// A four-entry queue separates intake from execution, so requests keep arriving
// while a result waits on a stalled receiver; req_full rises once it is full.
// Execution side: a load writes the bone table as it is popped. An applied influence
// is run by the single shared 42x20 multiplier stepping through 25 steps.
// Closing a point with nonzero weight then runs the bit-serial divider once per
// axis (a start, 64 steps and a capture) and then loads the result register.
// Reset empties the queue and clears the point sums, weight total, result valid flag
// and bones_in_use; the bone table is not cleared and must be loaded before use.
`default_nettype none

module linear_blend_skinning
   import lbs_pkg::*;
#(
   parameter int MAX_BONES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_func,
   input  wire logic [7:0]  req_bone,
   input  wire logic [15:0] req_weight,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic [15:0] req_quat_x,
   input  wire logic [15:0] req_quat_y,
   input  wire logic [15:0] req_quat_z,
   input  wire logic [15:0] req_quat_w,
   input  wire logic        req_last_influence,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [31:0]      rsp_point_x,
   output logic [31:0]      rsp_point_y,
   output logic [31:0]      rsp_point_z,
   output logic             rsp_has_weight,
   input  wire logic        csr_we,
   input  wire logic [6:0]  csr_wdata
);

   logic [6:0] bones_in_use_ff;
   job_type    req_job;
   queue_type  queue;
   logic       queue_pop;

   // Hold the configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         bones_in_use_ff <= '0;
      end else if (csr_we) begin
         bones_in_use_ff <= csr_wdata;
      end
   end

   // Gather the request fields
   always_comb begin
      req_job.kind       = KIND_SKIP;
      req_job.last       = req_last_influence;
      req_job.bone       = req_bone;
      req_job.weight     = req_weight;
      req_job.pos_x      = req_pos_x;
      req_job.pos_y      = req_pos_y;
      req_job.pos_z      = req_pos_z;
      req_job.quat_x     = req_quat_x;
      req_job.quat_y     = req_quat_y;
      req_job.quat_z     = req_quat_z;
      req_job.quat_w     = req_quat_w;
   end

   lbs_front #(
      .MAX_BONES (MAX_BONES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .bones_in_use (bones_in_use_ff),
      .push         (req_push),
      .full         (req_full),
      .req_job      (req_job),
      .req_func     (req_func),
      .req_last     (req_last_influence),
      .pop          (queue_pop),
      .queue        (queue)
   );

   lbs_back #(
      .MAX_BONES (MAX_BONES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue          (queue),
      .pop            (queue_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_point_z    (rsp_point_z),
      .rsp_has_weight (rsp_has_weight)
   );

endmodule

`default_nettype wire

// File: rtl/lbs_front.sv
// Request intake: classify each request and hold it in a short queue
`default_nettype none

module lbs_front
   import lbs_pkg::*;
#(
   parameter int MAX_BONES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [6:0]  bones_in_use,
   input  wire logic        push,
   output logic             full,
   input  wire job_type     req_job,
   input  wire logic        req_func,
   input  wire logic        req_last,
   input  wire logic        pop,
   output queue_type        queue
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   job_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]     count_ff, count_in;
   logic            in_range, active, keep, wr_en;
   job_type         entry;

   // Classify the incoming request
   always_comb begin
      in_range = {1'b0, req_job.bone} < 9'(MAX_BONES);
      active   = {1'b0, req_job.bone} < {2'b00, bones_in_use};
      entry    = req_job;
      entry.last = req_func & req_last;
      if (!req_func) begin
         entry.kind = in_range ? KIND_LOAD : KIND_SKIP;
      end else if (req_job.weight != 16'd0 && in_range && active) begin
         entry.kind = KIND_APPLY;
      end else begin
         entry.kind = KIND_SKIP;
      end
      // drop skips that close no point
      keep  = (entry.kind != KIND_SKIP) || entry.last;
      full  = (count_ff == (PW+1)'(DEPTH));
      wr_en = push && !full && keep;
   end

   // Advance pointers and fill count
   always_comb begin
      count_in = count_ff;
      if (wr_en && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Hold queued requests
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= entry;
      end
   end

   assign queue.empty = (count_ff == '0);
   assign queue.head  = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// File: rtl/lbs_div.sv
// Bit-serial signed divide by unsigned weight total, saturated to 32 bits
`default_nettype none

module lbs_div
   import lbs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [63:0]       dividend,
   input  wire logic [WT_W-1:0]   divisor,
   output logic                   busy,
   output logic                   done,
   output logic [31:0]            quotient
);

   logic              busy_ff, done_ff, neg_ff;
   logic [5:0]        count_ff;
   logic [WT_W-1:0]   rem_ff, dsr_ff, rem_in;
   logic [63:0]       quo_ff, quo_in;
   logic [31:0]       result_ff, result_in;
   logic [WT_W:0]     rem_sh;
   logic              ge;

   // One quotient bit per cycle, restoring
   always_comb begin
      rem_sh = {rem_ff, quo_ff[63]};
      ge     = rem_sh >= {1'b0, dsr_ff};
      rem_in = ge ? WT_W'(rem_sh - {1'b0, dsr_ff}) : rem_sh[WT_W-1:0];
      quo_in = {quo_ff[62:0], ge};
      if (!neg_ff) begin
         result_in = (quo_in > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_in[31:0];
      end else begin
         result_in = (quo_in > 64'h8000_0000) ? 32'h8000_0000 : 32'(-quo_in[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && count_ff == 6'd63) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff   <= dividend[63];
         quo_ff   <= dividend[63] ? 64'(-dividend) : dividend;
         rem_ff   <= '0;
         dsr_ff   <= divisor;
         count_ff <= '0;
      end else if (busy_ff) begin
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         count_ff <= count_ff + 1'b1;
         if (count_ff == 6'd63) begin
            result_ff <= result_in;
         end
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = result_ff;

endmodule

`default_nettype wire

// File: rtl/lbs_back.sv
// Execution side: bone table, rotate-and-accumulate sequencer, divide and result register
`default_nettype none
`include "linear_blend_skinning_assert.svh"

module lbs_back
   import lbs_pkg::*;
#(
   parameter int MAX_BONES = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire queue_type    queue,
   output logic              pop,
   input  wire logic         rsp_pop,
   output logic              rsp_empty,
   output logic [31:0]       rsp_point_x,
   output logic [31:0]       rsp_point_y,
   output logic [31:0]       rsp_point_z,
   output logic              rsp_has_weight
);

   localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
   localparam logic [4:0] STEP_END  = 5'd24;
   localparam logic [4:0] STEP_AXIS = 5'd13;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MAC  = 4'b0010,
      S_DIV  = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      ACC_LOAD = 2'd0,
      ACC_ADD  = 2'd1,
      ACC_SUB  = 2'd2
   } acc_op_type;

   typedef enum logic [2:0] {
      STO_NONE = 3'd0,
      STO_D    = 3'd1,
      STO_S    = 3'd2,
      STO_C    = 3'd3,
      STO_R    = 3'd4,
      STO_SUM  = 3'd5
   } sto_type;

   // Bone table
   logic [63:0] rot_mem [MAX_BONES];
   logic [63:0] txy_mem [MAX_BONES];
   logic [31:0] tz_mem  [MAX_BONES];
   logic [63:0] rot_rd_ff, txy_rd_ff;
   logic [31:0] tz_rd_ff;

   state_type   state_ff, state_in;
   logic [4:0]  step_ff;
   logic [1:0]  axis_ff;
   job_type     job_ff;
   logic        emit_load;

   logic signed [ACC_W-1:0]  acc_ff, acc_in, term, shifted;
   logic signed [OPA_W-1:0]  op_a;
   logic signed [OPB_W-1:0]  op_b;
   logic signed [PROD_W-1:0] prod;
   acc_op_type               acc_op;
   sto_type                  sto;
   logic                     dbl;
   logic [1:0]               mac_axis;
   logic [4:0]               idx;

   logic [35:0]      d_ff;
   logic [19:0]      s_ff;
   logic [35:0]      c0_ff, c1_ff, c2_ff;
   logic [OPA_W-1:0] r_ff, r_in;
   logic [63:0]      sum_x_ff, sum_y_ff, sum_z_ff, sum_sel, sum_new;
   logic [WT_W-1:0]  total_ff, total_in;
   logic [WT_W:0]    total_wide;
   logic [31:0]      quot_x_ff, quot_y_ff, quot_z_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      out_x_ff, out_y_ff, out_z_ff;
   logic             out_has_ff;

   logic             div_start, div_busy, div_done;
   logic [63:0]      div_dividend;
   logic [31:0]      div_quot;

   logic [15:0]      qx, qy, qz, qw, qk;
   logic [31:0]      vk, tk;
   logic [35:0]      ck;

   assign qx = rot_rd_ff[15:0];
   assign qy = rot_rd_ff[31:16];
   assign qz = rot_rd_ff[47:32];
   assign qw = rot_rd_ff[63:48];

   assign pop = state_ff == S_IDLE && !queue.empty;

   // Write and read the bone table, capture the popped request
   always_ff @(posedge clock) begin
      if (pop && queue.head.kind == KIND_LOAD) begin
         rot_mem[queue.head.bone[AW-1:0]] <= {queue.head.quat_w, queue.head.quat_z,
                                             queue.head.quat_y, queue.head.quat_x};
         txy_mem[queue.head.bone[AW-1:0]] <= {queue.head.pos_y, queue.head.pos_x};
         tz_mem[queue.head.bone[AW-1:0]]  <= queue.head.pos_z;
      end
      if (pop) begin
         job_ff    <= queue.head;
         rot_rd_ff <= rot_mem[queue.head.bone[AW-1:0]];
         txy_rd_ff <= txy_mem[queue.head.bone[AW-1:0]];
         tz_rd_ff  <= tz_mem[queue.head.bone[AW-1:0]];
      end
   end

   // Per-axis operand selection for the blend steps
   always_comb begin
      idx      = step_ff - STEP_AXIS;
      mac_axis = idx[3:2];
      case (mac_axis)
         2'd0: begin
            qk = qx; vk = job_ff.pos_x; ck = c0_ff; tk = txy_rd_ff[31:0];  sum_sel = sum_x_ff;
         end
         2'd1: begin
            qk = qy; vk = job_ff.pos_y; ck = c1_ff; tk = txy_rd_ff[63:32]; sum_sel = sum_y_ff;
         end
         default: begin
            qk = qz; vk = job_ff.pos_z; ck = c2_ff; tk = tz_rd_ff;         sum_sel = sum_z_ff;
         end
      endcase
   end

   // Step program of the shared multiplier
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      acc_op = ACC_LOAD;
      dbl    = 1'b0;
      sto    = STO_NONE;
      case (step_ff)
         5'd0:  begin op_a = OPA_W'($signed(job_ff.pos_x)); op_b = OPB_W'($signed(qx)); end
         5'd1:  begin op_a = OPA_W'($signed(job_ff.pos_y)); op_b = OPB_W'($signed(qy));
                      acc_op = ACC_ADD; end
         5'd2:  begin op_a = OPA_W'($signed(job_ff.pos_z)); op_b = OPB_W'($signed(qz));
                      acc_op = ACC_ADD; sto = STO_D; end
         5'd3:  begin op_a = OPA_W'($signed(qw)); op_b = OPB_W'($signed(qw)); end
         5'd4:  begin op_a = OPA_W'($signed(qx)); op_b = OPB_W'($signed(qx)); acc_op = ACC_SUB; end
         5'd5:  begin op_a = OPA_W'($signed(qy)); op_b = OPB_W'($signed(qy)); acc_op = ACC_SUB; end
         5'd6:  begin op_a = OPA_W'($signed(qz)); op_b = OPB_W'($signed(qz)); acc_op = ACC_SUB;
                      sto = STO_S; end
         5'd7:  begin op_a = OPA_W'($signed(job_ff.pos_z)); op_b = OPB_W'($signed(qy)); end
         5'd8:  begin op_a = OPA_W'($signed(job_ff.pos_y)); op_b = OPB_W'($signed(qz));
                      acc_op = ACC_SUB; sto = STO_C; end
         5'd9:  begin op_a = OPA_W'($signed(job_ff.pos_x)); op_b = OPB_W'($signed(qz)); end
         5'd10: begin op_a = OPA_W'($signed(job_ff.pos_z)); op_b = OPB_W'($signed(qx));
                      acc_op = ACC_SUB; sto = STO_C; end
         5'd11: begin op_a = OPA_W'($signed(job_ff.pos_y)); op_b = OPB_W'($signed(qx)); end
         5'd12: begin op_a = OPA_W'($signed(job_ff.pos_x)); op_b = OPB_W'($signed(qy));
                      acc_op = ACC_SUB; sto = STO_C; end
         default: begin
            case (idx[1:0])
               2'd0: begin op_a = OPA_W'($signed(d_ff)); op_b = OPB_W'($signed(qk)); dbl = 1'b1; end
               2'd1: begin op_a = OPA_W'($signed(vk)); op_b = $signed(s_ff); acc_op = ACC_ADD; end
               2'd2: begin op_a = OPA_W'($signed(ck)); op_b = OPB_W'($signed(qw));
                           acc_op = ACC_ADD; dbl = 1'b1; sto = STO_R; end
               default: begin op_a = $signed(r_ff); op_b = {4'b0000, job_ff.weight};
                              sto = STO_SUM; end
            endcase
         end
      endcase
   end

   // Multiply and accumulate
   always_comb begin
      prod = op_a * op_b;
      term = dbl ? (prod[ACC_W-1:0] <<< 1) : prod[ACC_W-1:0];
      case (acc_op)
         ACC_ADD: acc_in = acc_ff + term;
         ACC_SUB: acc_in = acc_ff - term;
         default: acc_in = term;
      endcase
      shifted    = acc_in >>> FRAC_Q;
      r_in       = shifted[OPA_W-1:0] + OPA_W'($signed(tk));
      sum_new    = sat_add64(sum_sel, 64'($signed(prod)));
      total_wide = {1'b0, total_ff} + (WT_W+1)'(job_ff.weight);
      total_in   = total_wide[WT_W] ? {WT_W{1'b1}} : total_wide[WT_W-1:0];
   end

   // Hold intermediate terms
   always_ff @(posedge clock) begin
      if (state_ff == S_MAC) begin
         acc_ff <= acc_in;
         case (sto)
            STO_D: d_ff <= shifted[35:0];
            STO_S: s_ff <= shifted[19:0];
            STO_C: begin
               if (step_ff == 5'd8) begin
                  c0_ff <= shifted[35:0];
               end else if (step_ff == 5'd10) begin
                  c1_ff <= shifted[35:0];
               end else begin
                  c2_ff <= shifted[35:0];
               end
            end
            STO_R: r_ff <= r_in;
            default: ;
         endcase
      end
   end

   // Divider feed
   always_comb begin
      case (axis_ff)
         2'd0:    div_dividend = sum_x_ff;
         2'd1:    div_dividend = sum_y_ff;
         default: div_dividend = sum_z_ff;
      endcase
      div_start = state_ff == S_DIV && !div_busy && !div_done;
   end

   lbs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (total_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Next state and result valid
   always_comb begin
      state_in     = state_ff;
      emit_load    = state_ff == S_EMIT && (!rsp_valid_ff || rsp_pop);
      rsp_valid_in = emit_load || (rsp_valid_ff && !rsp_pop);
      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               if (queue.head.kind == KIND_APPLY) begin
                  state_in = S_MAC;
               end else if (queue.head.kind == KIND_SKIP && queue.head.last) begin
                  state_in = (total_ff != '0) ? S_DIV : S_EMIT;
               end
            end
         end
         S_MAC: begin
            if (step_ff == STEP_END) begin
               if (!job_ff.last) begin
                  state_in = S_IDLE;
               end else if (total_in != '0) begin
                  state_in = S_DIV;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_DIV: begin
            if (div_done && axis_ff == 2'd2) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control, accumulators and result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         axis_ff      <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_z_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            S_IDLE: begin
               step_ff <= '0;
               axis_ff <= '0;
            end
            S_MAC: begin
               step_ff <= step_ff + 1'b1;
               if (sto == STO_SUM) begin
                  case (mac_axis)
                     2'd0:    sum_x_ff <= sum_new;
                     2'd1:    sum_y_ff <= sum_new;
                     default: sum_z_ff <= sum_new;
                  endcase
               end
               if (step_ff == STEP_END) begin
                  total_ff <= total_in;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  axis_ff <= axis_ff + 1'b1;
               end
            end
            S_EMIT: begin
               if (emit_load) begin
                  sum_x_ff <= '0;
                  sum_y_ff <= '0;
                  sum_z_ff <= '0;
                  total_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // Capture quotients and load the result register
   always_ff @(posedge clock) begin
      if (state_ff == S_DIV && div_done) begin
         case (axis_ff)
            2'd0:    quot_x_ff <= div_quot;
            2'd1:    quot_y_ff <= div_quot;
            default: quot_z_ff <= div_quot;
         endcase
      end
      if (emit_load) begin
         out_has_ff <= total_ff != '0;
         out_x_ff   <= (total_ff != '0) ? quot_x_ff : 32'd0;
         out_y_ff   <= (total_ff != '0) ? quot_y_ff : 32'd0;
         out_z_ff   <= (total_ff != '0) ? quot_z_ff : 32'd0;
      end
   end

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_point_x    = out_x_ff;
   assign rsp_point_y    = out_y_ff;
   assign rsp_point_z    = out_z_ff;
   assign rsp_has_weight = out_has_ff;

   `LBS_ASSERT_IMPL(a_pop_idle, clock, reset, pop, state_ff == S_IDLE && !queue.empty)
   `LBS_ASSERT_IMPL(a_div_free, clock, reset, div_start, !div_busy && total_ff != '0)
   `LBS_ASSERT_NEXT(a_emit_hold, clock, reset,
      state_ff == S_EMIT && rsp_valid_ff && !rsp_pop, state_ff == S_EMIT)
   `LBS_ASSERT_IMPL(a_step_range, clock, reset, state_ff == S_MAC, step_ff <= STEP_END)

endmodule

`default_nettype wire

// File: verif/lbs_test_pkg.sv
// Request codes and table size shared by the skinning testbench files
package lbs_test_pkg;

   localparam bit FUNC_LOAD      = 1'b0;
   localparam bit FUNC_INFLUENCE = 1'b1;
   localparam int BONE_SLOTS     = 64;

endpackage

// File: verif/linear_blend_skinning_check.sv
// Checker for the skinning block: predicts each skinned point and compares it
module linear_blend_skinning_check
   import lbs_test_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_func,
   input  logic [7:0]  req_bone,
   input  logic [15:0] req_weight,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [15:0] req_quat_x,
   input  logic [15:0] req_quat_y,
   input  logic [15:0] req_quat_z,
   input  logic [15:0] req_quat_w,
   input  logic        req_last_influence,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [31:0] rsp_point_x,
   input  logic [31:0] rsp_point_y,
   input  logic [31:0] rsp_point_z,
   input  logic        rsp_has_weight,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata,
   input  logic        done,
   output int          failures
);

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        has_weight;
   } point_type;

   localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint SUM_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

   // Shadow bone table and accumulators
   longint    rot_q [BONE_SLOTS][4];
   longint    trans [BONE_SLOTS][3];
   longint    acc [3];
   int        weight_sum;
   int        bones_limit;
   point_type points_due [$];
   int        mismatches;
   bit        tallied;

   assign failures = mismatches;

   function automatic longint sat_sum(input longint a, input longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
         return a[63] ? SUM_MIN : SUM_MAX;
      return s;
   endfunction

   function automatic logic [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // Rotate a Q16.16 position by a Q1.14 quaternion, floor at each rescale
   function automatic void rotate_pos(input longint q[4], input longint v[3],
                                      output longint r[3]);
      longint d, s, t;
      longint c[3];
      d = (q[0] * v[0] + q[1] * v[1] + q[2] * v[2]) >>> 14;
      s = (q[3] * q[3] - q[0] * q[0] - q[1] * q[1] - q[2] * q[2]) >>> 14;
      c[0] = (q[1] * v[2] - q[2] * v[1]) >>> 14;
      c[1] = (q[2] * v[0] - q[0] * v[2]) >>> 14;
      c[2] = (q[0] * v[1] - q[1] * v[0]) >>> 14;
      for (int i = 0; i < 3; i++) begin
         t = 2 * q[i] * d + s * v[i] + 2 * q[3] * c[i];
         r[i] = t >>> 14;
      end
   endfunction

   // Advance the shadow state on each accepted request
   always @(posedge clock) begin
      longint    v[3];
      longint    r[3];
      point_type p;
      if (reset) begin
         acc = '{0, 0, 0};
         weight_sum = 0;
         bones_limit = 0;
         points_due.delete();
         mismatches = 0;
         tallied = 0;
      end else begin
         if (csr_we)
            bones_limit = csr_wdata;
         if (req_push && !req_full) begin
            if (req_func == FUNC_LOAD) begin
               if (req_bone < BONE_SLOTS) begin
                  rot_q[req_bone] = '{longint'($signed(req_quat_x)),
                     longint'($signed(req_quat_y)), longint'($signed(req_quat_z)),
                     longint'($signed(req_quat_w))};
                  trans[req_bone] = '{longint'($signed(req_pos_x)),
                     longint'($signed(req_pos_y)), longint'($signed(req_pos_z))};
               end
            end else begin
               if (req_weight != 0 && req_bone < bones_limit
                   && req_bone < BONE_SLOTS) begin
                  v = '{longint'($signed(req_pos_x)), longint'($signed(req_pos_y)),
                        longint'($signed(req_pos_z))};
                  rotate_pos(rot_q[req_bone], v, r);
                  for (int i = 0; i < 3; i++)
                     acc[i] = sat_sum(acc[i],
                        (r[i] + trans[req_bone][i]) * longint'(req_weight));
                  weight_sum = weight_sum + req_weight;
                  if (weight_sum > 24'hFF_FFFF)
                     weight_sum = 24'hFF_FFFF;
               end
               if (req_last_influence) begin
                  if (weight_sum != 0) begin
                     p.x = clamp32(acc[0] / longint'(weight_sum));
                     p.y = clamp32(acc[1] / longint'(weight_sum));
                     p.z = clamp32(acc[2] / longint'(weight_sum));
                     p.has_weight = 1'b1;
                  end else begin
                     p = '{32'd0, 32'd0, 32'd0, 1'b0};
                  end
                  points_due.insert(points_due.size(), p);
                  acc = '{0, 0, 0};
                  weight_sum = 0;
               end
            end
         end

         // Compare each popped point with the oldest prediction
         if (rsp_pop && !rsp_empty) begin
            if (points_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected point %h %h %h %b", rsp_point_x, rsp_point_y,
                           rsp_point_z, rsp_has_weight);
            end else begin
               p = points_due.pop_front();
               if (rsp_point_x !== p.x || rsp_point_y !== p.y || rsp_point_z !== p.z
                   || rsp_has_weight !== p.has_weight) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("point mismatch: expected %h %h %h %b, got %h %h %h %b",
                              p.x, p.y, p.z, p.has_weight, rsp_point_x, rsp_point_y,
                              rsp_point_z, rsp_has_weight);
               end
            end
         end

         // Count predictions never matched once stimulus is over
         if (done && !tallied) begin
            tallied = 1;
            if (points_due.size() != 0) begin
               $display("%0d points never arrived", points_due.size());
               mismatches += points_due.size();
            end
         end
      end
   end

endmodule

// File: verif/linear_blend_skinning_test.sv
// Stimulus, idling control and verdict for the skinning block
module linear_blend_skinning_test;
   import lbs_test_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   logic        req_func = 0;
   logic [7:0]  req_bone = 0;
   logic [15:0] req_weight = 0;
   logic [31:0] req_pos_x = 0;
   logic [31:0] req_pos_y = 0;
   logic [31:0] req_pos_z = 0;
   logic [15:0] req_quat_x = 0;
   logic [15:0] req_quat_y = 0;
   logic [15:0] req_quat_z = 0;
   logic [15:0] req_quat_w = 0;
   logic        req_last_influence = 0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic [31:0] rsp_point_x;
   logic [31:0] rsp_point_y;
   logic [31:0] rsp_point_z;
   logic        rsp_has_weight;
   logic        csr_we = 0;
   logic [6:0]  csr_wdata = 0;
   logic        done = 0;
   int          failures;

   int send_pct = 0;
   int recv_pct = 0;
   bit start_hold = 0;
   int hold_left = 0;
   int points_sent = 0;
   int points_taken = 0;
   int bones_now = 0;
   int quiet_cycles = 0;
   bit loaded [BONE_SLOTS];

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   linear_blend_skinning dut (.*);

   linear_blend_skinning_check checker_inst (.*);

   // Receiver: random pops, with a long hold-off on request
   always @(posedge clock) begin
      if (start_hold) begin
         start_hold = 0;
         hold_left = 3000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_pct);
      end
      if (!reset && rsp_pop && !rsp_empty)
         points_taken++;
   end

   // Watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offer one request and hold it until taken
   task automatic send(input bit f, input logic [7:0] idx, input logic [15:0] w,
                       input logic [31:0] px, input logic [31:0] py,
                       input logic [31:0] pz, input logic [15:0] qx,
                       input logic [15:0] qy, input logic [15:0] qz,
                       input logic [15:0] qw, input bit last);
      while ($urandom_range(99) < send_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_func <= f;
      req_bone <= idx;
      req_weight <= w;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_quat_x <= qx;
      req_quat_y <= qy;
      req_quat_z <= qz;
      req_quat_w <= qw;
      req_last_influence <= last;
      do @(posedge clock); while (req_full);
      if (f == FUNC_LOAD && idx < BONE_SLOTS)
         loaded[idx] = 1;
      if (f == FUNC_INFLUENCE && last)
         points_sent++;
   endtask

   function automatic logic [15:0] rand_quat_part();
      case ($urandom_range(5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'd0;
         default: return $urandom_range(32768) - 16384;
      endcase
   endfunction

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(3))
         0: return $urandom;
         default: return $urandom_range(32'h0800_0000) - 32'h0400_0000;
      endcase
   endfunction

   // Load a bone with random rotation and translation
   task automatic load_bone(input logic [7:0] idx);
      send(FUNC_LOAD, idx, $urandom, rand_pos(), rand_pos(), rand_pos(),
           rand_quat_part(), rand_quat_part(), rand_quat_part(), rand_quat_part(),
           $urandom_range(1));
   endtask

   // Apply an influence, loading its bone first if the influence counts and the bone has never been written
   task automatic influence(input logic [7:0] idx, input logic [15:0] w, input bit last);
      if (w != 0 && idx < bones_now && idx < BONE_SLOTS && !loaded[idx])
         load_bone(idx);
      send(FUNC_INFLUENCE, idx, w, rand_pos(), rand_pos(), rand_pos(),
           $urandom, $urandom, $urandom, $urandom, last);
   endtask

   // Drop push, drain every point, then let trailing requests finish
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (points_taken != points_sent)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_bones(input int n);
      csr_we <= 1'b1;
      csr_wdata <= n;
      @(posedge clock);
      csr_we <= 1'b0;
      bones_now = n;
      @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      logic [7:0]  idx;
      logic [15:0] w;
      for (int i = 0; i < count; i++) begin
         idx = ($urandom_range(99) < 85) ? $urandom_range(BONE_SLOTS - 1) : $urandom;
         if ($urandom_range(99) < 20) begin
            load_bone(idx);
         end else begin
            case ($urandom_range(9))
               0: w = 16'd0;
               1: w = 16'hFFFF;
               default: w = $urandom;
            endcase
            influence(idx, w, $urandom_range(3) == 0);
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: no bones in use, so every influence is skipped
      set_bones(0);
      influence(8'd0, 16'hFFFF, 1'b1);
      influence(8'd5, 16'd1, 1'b1);
      settle();

      // Directed: extreme loads and influences
      set_bones(BONE_SLOTS);
      send(FUNC_LOAD, 8'd0, 16'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
           16'd0, 16'd0, 16'd0, 16'sd16384, 1'b0);
      send(FUNC_LOAD, 8'd63, 16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 1'b1);
      send(FUNC_LOAD, 8'd255, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send(FUNC_INFLUENCE, 8'd0, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
           16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
      send(FUNC_INFLUENCE, 8'd63, 16'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send(FUNC_INFLUENCE, 8'd0, 16'd0, 32'h1234_5678, 32'd0, 32'd0,
           16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
      send(FUNC_INFLUENCE, 8'd64, 16'd100, 32'd0, 32'd0, 32'd0,
           16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
      send(FUNC_INFLUENCE, 8'd255, 16'hFFFF, 32'd0, 32'd0, 32'd0,
           16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
      send(FUNC_INFLUENCE, 8'd63, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
           16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
      send(FUNC_INFLUENCE, 8'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000,
           16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
      settle();

      // Random: sender idles lightly, receiver heavily; table limit above its size
      send_pct = 23;
      recv_pct = 73;
      set_bones(127);
      random_phase(160);
      settle();

      // Random: swapped idling, a random table limit
      send_pct = 73;
      recv_pct = 23;
      set_bones($urandom_range(1, BONE_SLOTS));
      random_phase(120);
      settle();

      // No idling: hold the receiver off so the block fills and stalls intake
      send_pct = 0;
      recv_pct = 0;
      set_bones(BONE_SLOTS);
      start_hold = 1;
      random_phase(40);
      // One long point to reach the weight total ceiling
      for (int i = 0; i < 259; i++)
         influence(8'd0, 16'hFFFF, i == 258);
      random_phase(60);
      settle();

      done <= 1'b1;
      repeat (2) @(posedge clock);
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/lbs_pkg.sv
rtl/lbs_front.sv
rtl/lbs_div.sv
rtl/lbs_back.sv
rtl/linear_blend_skinning.sv
verif/lbs_test_pkg.sv
verif/linear_blend_skinning_check.sv
verif/linear_blend_skinning_test.sv
